[src/cmc_pkg.sv]
// Shared types and constants of the centroid Morton key pipeline.
package cmc_pkg;

    localparam int GRID_BITS  = 10;
    localparam int KEY_BITS   = 3 * GRID_BITS;
    localparam int WORD_BITS  = 32;
    localparam int ADDR_BITS  = 5;
    localparam int D_BITS     = 35;
    localparam int UD_BITS    = 33;
    localparam int HALF_BITS  = 16;
    localparam int PROD_BITS  = UD_BITS + HALF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int Q_SHIFT    = 17;
    localparam int Q_BITS     = SUM_BITS - Q_SHIFT;

    localparam logic [WORD_BITS-1:0] SCALE_RESET = 32'h0001_0000;

    typedef logic signed [WORD_BITS-1:0] coord_t;
    typedef logic [WORD_BITS-1:0] scale_t;
    typedef logic [GRID_BITS-1:0] grid_t;

    typedef enum logic [2:0] {
        REG_MAP_MIN_X = 3'd0,
        REG_MAP_MIN_Y = 3'd1,
        REG_MAP_MIN_Z = 3'd2,
        REG_SCALE_X   = 3'd3,
        REG_SCALE_Y   = 3'd4,
        REG_SCALE_Z   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic   kind;
        coord_t v1_x;
        coord_t v1_y;
        coord_t v1_z;
        coord_t v2_x;
        coord_t v2_y;
        coord_t v2_z;
        coord_t v3_x;
        coord_t v3_y;
        coord_t v3_z;
        logic   last_item;
    } in_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] morton_key;
        logic                last_key;
    } out_t;

    typedef struct packed {
        coord_t map_min_x;
        coord_t map_min_y;
        coord_t map_min_z;
        scale_t scale_x;
        scale_t scale_y;
        scale_t scale_z;
    } cfg_t;

    typedef struct packed {
        coord_t lo;
        coord_t hi;
    } span_t;

endpackage

[src/cmc_regs.sv]
// APB configuration register file holding the map minimum and axis scales.
module cmc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cmc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [cmc_pkg::WORD_BITS-1:0]  pwdata,
    output logic [cmc_pkg::WORD_BITS-1:0]  prdata,
    output logic                           pready,
    output cmc_pkg::cfg_t                  cfg
);

    cmc_pkg::cfg_t cfg_reg;
    cmc_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                cmc_pkg::REG_MAP_MIN_X: cfg_next.map_min_x = pwdata;
                cmc_pkg::REG_MAP_MIN_Y: cfg_next.map_min_y = pwdata;
                cmc_pkg::REG_MAP_MIN_Z: cfg_next.map_min_z = pwdata;
                cmc_pkg::REG_SCALE_X:   cfg_next.scale_x   = pwdata;
                cmc_pkg::REG_SCALE_Y:   cfg_next.scale_y   = pwdata;
                cmc_pkg::REG_SCALE_Z:   cfg_next.scale_z   = pwdata;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            cmc_pkg::REG_MAP_MIN_X: prdata = cfg_reg.map_min_x;
            cmc_pkg::REG_MAP_MIN_Y: prdata = cfg_reg.map_min_y;
            cmc_pkg::REG_MAP_MIN_Z: prdata = cfg_reg.map_min_z;
            cmc_pkg::REG_SCALE_X:   prdata = cfg_reg.scale_x;
            cmc_pkg::REG_SCALE_Y:   prdata = cfg_reg.scale_y;
            cmc_pkg::REG_SCALE_Z:   prdata = cfg_reg.scale_z;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_min_x <= '0;
            cfg_reg.map_min_y <= '0;
            cfg_reg.map_min_z <= '0;
            cfg_reg.scale_x   <= cmc_pkg::SCALE_RESET;
            cfg_reg.scale_y   <= cmc_pkg::SCALE_RESET;
            cfg_reg.scale_z   <= cmc_pkg::SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/cmc_bounds.sv]
// First pipeline stage: reduces a triangle or a box to a low and high value per axis.
module cmc_bounds (
    input  logic           clk,
    input  logic           en,
    input  cmc_pkg::in_t   prim,
    output cmc_pkg::span_t span_x,
    output cmc_pkg::span_t span_y,
    output cmc_pkg::span_t span_z
);

    cmc_pkg::span_t span_x_reg, span_x_next;
    cmc_pkg::span_t span_y_reg, span_y_next;
    cmc_pkg::span_t span_z_reg, span_z_next;

    function automatic cmc_pkg::span_t reduce(
        input logic            box,
        input cmc_pkg::coord_t a,
        input cmc_pkg::coord_t b,
        input cmc_pkg::coord_t c
    );
        cmc_pkg::span_t  s;
        cmc_pkg::coord_t mn;
        cmc_pkg::coord_t mx;
        mn = (a < b) ? a : b;
        mn = (mn < c) ? mn : c;
        mx = (a > b) ? a : b;
        mx = (mx > c) ? mx : c;
        if (box)
        begin
            s.lo = a;
            s.hi = b;
        end
        else
        begin
            s.lo = mn;
            s.hi = mx;
        end
        return s;
    endfunction

    assign span_x_next = reduce(prim.kind, prim.v1_x, prim.v2_x, prim.v3_x);
    assign span_y_next = reduce(prim.kind, prim.v1_y, prim.v2_y, prim.v3_y);
    assign span_z_next = reduce(prim.kind, prim.v1_z, prim.v2_z, prim.v3_z);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            span_x_reg <= span_x_next;
            span_y_reg <= span_y_next;
            span_z_reg <= span_z_next;
        end
    end

    assign span_x = span_x_reg;
    assign span_y = span_y_reg;
    assign span_z = span_z_reg;

endmodule

[src/cmc_axis.sv]
// Offset, scale multiply and clamp of one axis over three pipeline stages.
module cmc_axis (
    input  logic            clk,
    input  logic            en,
    input  cmc_pkg::span_t  span,
    input  cmc_pkg::coord_t map_min,
    input  cmc_pkg::scale_t scale,
    output cmc_pkg::grid_t  grid
);

    logic signed [cmc_pkg::D_BITS-1:0]    d_reg, d_next;
    logic        [cmc_pkg::UD_BITS-1:0]   ud;
    logic        [cmc_pkg::PROD_BITS-1:0] prod_hi_reg, prod_hi_next;
    logic        [cmc_pkg::PROD_BITS-1:0] prod_lo_reg, prod_lo_next;
    logic        [cmc_pkg::SUM_BITS-1:0]  sum;
    logic        [cmc_pkg::Q_BITS-1:0]    q;
    cmc_pkg::grid_t                       grid_reg, grid_next;

    assign d_next = cmc_pkg::D_BITS'(span.lo) + cmc_pkg::D_BITS'(span.hi)
                  - (cmc_pkg::D_BITS'(map_min) <<< 1);

    // A centroid at or below the map minimum maps to grid zero.
    assign ud = (d_reg > 0) ? d_reg[cmc_pkg::UD_BITS-1:0] : '0;

    assign prod_hi_next = cmc_pkg::PROD_BITS'(ud)
                        * cmc_pkg::PROD_BITS'(scale[cmc_pkg::WORD_BITS-1:cmc_pkg::HALF_BITS]);
    assign prod_lo_next = cmc_pkg::PROD_BITS'(ud)
                        * cmc_pkg::PROD_BITS'(scale[cmc_pkg::HALF_BITS-1:0]);

    assign sum = cmc_pkg::SUM_BITS'(prod_hi_reg)
               + cmc_pkg::SUM_BITS'(prod_lo_reg >> cmc_pkg::HALF_BITS);
    assign q   = sum[cmc_pkg::SUM_BITS-1:cmc_pkg::Q_SHIFT];

    assign grid_next = (|q[cmc_pkg::Q_BITS-1:cmc_pkg::GRID_BITS]) ? '1
                     : q[cmc_pkg::GRID_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg       <= d_next;
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            grid_reg    <= grid_next;
        end
    end

    assign grid = grid_reg;

endmodule

[src/centroid_morton_code_3d.sv]
// Top level of the centroid Morton key pipeline with its configuration port.
// An accepted word moves through the bounds, offset, product, grid and key registers.
// Throughput: one word per cycle; the five-stage pipeline advances whenever the
// output register is empty or its key word is being taken, and stalls as a whole.
// Reset clears all valid bits and loads the register defaults (map minimum 0, scale 1.0).
module centroid_morton_code_3d (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           prim_valid,
    output logic                           prim_ready,
    input  cmc_pkg::in_t                   prim,
    output logic                           key_valid,
    input  logic                           key_ready,
    output cmc_pkg::out_t                  key,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cmc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [cmc_pkg::WORD_BITS-1:0]  pwdata,
    output logic [cmc_pkg::WORD_BITS-1:0]  prdata,
    output logic                           pready
);

    cmc_pkg::cfg_t  cfg;
    cmc_pkg::span_t span_x, span_y, span_z;
    cmc_pkg::grid_t grid_x, grid_y, grid_z;
    logic           en;
    logic [3:0]     stage_valid_reg, stage_valid_next;
    logic [3:0]     stage_last_reg, stage_last_next;
    logic           key_valid_reg, key_valid_next;
    cmc_pkg::out_t  key_reg, key_next;

    function automatic logic [cmc_pkg::KEY_BITS-1:0] interleave(
        input cmc_pkg::grid_t gx,
        input cmc_pkg::grid_t gy,
        input cmc_pkg::grid_t gz
    );
        logic [cmc_pkg::KEY_BITS-1:0] k;
        k = '0;
        for (int i = 0; i < cmc_pkg::GRID_BITS; i++)
        begin
            k[3*i+2] = gx[i];
            k[3*i+1] = gy[i];
            k[3*i]   = gz[i];
        end
        return k;
    endfunction

    cmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cmc_bounds u_bounds (
        .clk    (clk),
        .en     (en),
        .prim   (prim),
        .span_x (span_x),
        .span_y (span_y),
        .span_z (span_z)
    );

    cmc_axis u_axis_x (
        .clk     (clk),
        .en      (en),
        .span    (span_x),
        .map_min (cfg.map_min_x),
        .scale   (cfg.scale_x),
        .grid    (grid_x)
    );

    cmc_axis u_axis_y (
        .clk     (clk),
        .en      (en),
        .span    (span_y),
        .map_min (cfg.map_min_y),
        .scale   (cfg.scale_y),
        .grid    (grid_y)
    );

    cmc_axis u_axis_z (
        .clk     (clk),
        .en      (en),
        .span    (span_z),
        .map_min (cfg.map_min_z),
        .scale   (cfg.scale_z),
        .grid    (grid_z)
    );

    assign en         = !key_valid_reg || key_ready;
    assign prim_ready = en;

    assign stage_valid_next    = {stage_valid_reg[2:0], prim_valid && en};
    assign stage_last_next     = {stage_last_reg[2:0], prim.last_item};
    assign key_valid_next      = stage_valid_reg[3];
    assign key_next.morton_key = interleave(grid_x, grid_y, grid_z);
    assign key_next.last_key   = stage_last_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            key_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            stage_valid_reg <= stage_valid_next;
            key_valid_reg   <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_last_reg <= stage_last_next;
            key_reg        <= key_next;
        end
    end

    assign key_valid = key_valid_reg;
    assign key       = key_reg;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        prim_valid && prim_ready |=> stage_valid_reg[0])
        else $error("Accepted word did not enter the first stage.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stage_valid_reg) && $stable(key_valid_reg))
        else $error("Pipeline valid bits changed during a stall.");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        en && stage_valid_reg[3] |=> key_valid && (key.last_key == $past(stage_last_reg[3])))
        else $error("Last stage word was not delivered with its batch mark.");

    a_bubble_drains: assert property (@(posedge clk) disable iff (!rst_n)
        en && !stage_valid_reg[3] |=> !key_valid)
        else $error("Key word appeared without a valid word in the last stage.");
`endif

endmodule
